// ===== rtl/lkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  // Operation codes carried in the kind field.
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Width and reset value of the capacity register.
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Value returned by a get that finds nothing.
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

  // Status of one associative search.
  typedef struct packed {
    logic hit;
    logic free_found;
  } search_flags_t;

endpackage

`default_nettype wire

// ===== rtl/lkv_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkv_search
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic signed [31:0]                                 key,
  input  logic signed [31:0]                                 keys [ENTRIES],
  input  logic        [ENTRIES-1:0]                          valid,
  input  logic        [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] ranks [ENTRIES],
  input  logic        [$clog2(ENTRIES+1)-1:0]                occupancy,
  output search_flags_t                                      flags,
  output logic        [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_idx,
  output logic        [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] victim_idx,
  output logic        [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IW-1:0] oldest_rank;

  // The valid slots always hold ranks 0 .. occupancy-1, so the least recent
  // one is the single valid slot whose rank equals occupancy-1.
  assign oldest_rank = IW'(occupancy - 1'b1);

  always_comb begin
    flags      = '0;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && (keys[i] == key) && !flags.hit) begin
        flags.hit = 1'b1;
        hit_idx   = IW'(i);
      end
      if (!valid[i] && !flags.free_found) begin
        flags.free_found = 1'b1;
        free_idx         = IW'(i);
      end
      if (valid[i] && (ranks[i] == oldest_rank)) begin
        victim_idx = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
//
// Request channel: an item (kind, key, value) is taken at a rising edge where
// start is high and busy is low. busy is only raised while rst is asserted, so
// one item may be issued in every cycle.
// Result channel: each item produces exactly one result, shown on result for a
// single cycle with done high. The receiver cannot stall; it must take the
// result in that cycle.
// The item is captured in the request register; on the next edge the parallel
// key compare, rank update and store write happen together with the capture
// of the result, and done rises together with it.
// Sustained throughput is one item per clock; the next item sees the store as
// left by the previous one because both the state and the result register are
// written on the same edge.
// Configuration: cfg_data loads the capacity register when cfg_valid is high.
// cfg_ready is always high. The write is only honoured while the store is
// empty; otherwise the register keeps its value. Capacities of zero or above
// ENTRIES behave as one and ENTRIES respectively.
// Reset (synchronous, active high) clears all valid bits, ranks and the
// occupancy count and sets the capacity back to sixteen. No clearing pass is
// needed, so the block takes items from the first cycle after reset.

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             request,
  output logic             done,
  output rsp_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int LW = (OW > CAP_W) ? OW : CAP_W;

  // Request register.
  logic          req_valid;
  req_t          req;

  // Store state.
  logic signed [31:0] key_store   [ENTRIES];
  logic signed [31:0] value_store [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] entry_valid_next;
  logic [IW-1:0]      recency_rank      [ENTRIES];
  logic [IW-1:0]      recency_rank_next [ENTRIES];
  logic [OW-1:0]      occupancy;
  logic [OW-1:0]      occupancy_next;
  logic [CAP_W-1:0]   capacity;

  // Search results and decisions for the item in the request register.
  search_flags_t flags;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] victim_idx;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] ins_idx;
  logic [LW-1:0] limit;
  logic          full;
  logic          do_hit;
  logic          do_ins;
  logic          do_evict;
  logic          write_value;
  logic [IW-1:0] write_idx;
  rsp_t          result_next;

  // Items are accepted every cycle; only reset holds them off.
  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
  end

  lkv_search #(
    .ENTRIES (ENTRIES)
  ) u_search (
    .key        (req.key),
    .keys       (key_store),
    .valid      (entry_valid),
    .ranks      (recency_rank),
    .occupancy  (occupancy),
    .flags      (flags),
    .hit_idx    (hit_idx),
    .victim_idx (victim_idx),
    .free_idx   (free_idx)
  );

  // Effective capacity: zero behaves as one, anything above the store size
  // behaves as the store size.
  always_comb begin
    if (capacity == '0) begin
      limit = LW'(1);
    end else if (LW'(capacity) > LW'(ENTRIES)) begin
      limit = LW'(ENTRIES);
    end else begin
      limit = LW'(capacity);
    end
  end

  assign full     = LW'(occupancy) >= limit;
  assign do_hit   = req_valid && flags.hit;
  assign do_ins   = req_valid && (req.kind == KIND_PUT) && !flags.hit
                    && (full || flags.free_found);
  assign do_evict = do_ins && full;
  assign ins_idx  = full ? victim_idx : free_idx;

  // A put that hits overwrites in place; a put that misses fills the chosen slot.
  assign write_value = do_ins || (do_hit && (req.kind == KIND_PUT));
  assign write_idx   = do_ins ? ins_idx : hit_idx;

  // Rank update. On a hit, entries more recent than the hit entry age by one.
  // On an insert every other valid entry ages by one; an evicted entry is the
  // target slot itself and so is excluded.
  always_comb begin
    entry_valid_next = entry_valid;
    occupancy_next   = occupancy;
    for (int i = 0; i < ENTRIES; i++) begin
      recency_rank_next[i] = recency_rank[i];
      if (do_hit && entry_valid[i] && (IW'(i) != hit_idx)
          && (recency_rank[i] < recency_rank[hit_idx])) begin
        recency_rank_next[i] = recency_rank[i] + 1'b1;
      end
      if (do_ins && entry_valid[i] && (IW'(i) != ins_idx)) begin
        recency_rank_next[i] = recency_rank[i] + 1'b1;
      end
    end
    if (do_hit) begin
      recency_rank_next[hit_idx] = '0;
    end
    if (do_ins) begin
      recency_rank_next[ins_idx] = '0;
      entry_valid_next[ins_idx]  = 1'b1;
      if (!do_evict) begin
        occupancy_next = occupancy + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      entry_valid  <= entry_valid_next;
      occupancy    <= occupancy_next;
      recency_rank <= recency_rank_next;
    end
  end

  // Capacity only changes while the store is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready && (occupancy == '0)) begin
      capacity <= cfg_data;
    end
  end

  // Key and value stores: no reset, only valid slots are ever looked at.
  always_ff @(posedge clk) begin
    if (do_ins) begin
      key_store[ins_idx] <= req.key;
    end
    if (write_value) begin
      value_store[write_idx] <= req.value;
    end
  end

  always_comb begin
    result_next.found       = flags.hit;
    result_next.evicted     = do_evict;
    result_next.evicted_key = do_evict ? key_store[victim_idx] : '0;
    if (req.kind == KIND_GET) begin
      result_next.read_value = flags.hit ? value_store[hit_idx] : MISS_VALUE;
    end else begin
      result_next.read_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result <= result_next;
    end
  end

  // The occupancy count tracks the valid bits exactly.
  assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == 32'(occupancy))
    else $error("occupancy count disagrees with valid bits");

  // The store never holds more entries than it has slots.
  assert property (@(posedge clk) disable iff (rst)
    LW'(occupancy) <= LW'(ENTRIES))
    else $error("occupancy above store size");

  // An eviction only ever comes from a put that missed.
  assert property (@(posedge clk) disable iff (rst)
    done && result.evicted |-> !result.found && (result.read_value == '0))
    else $error("eviction reported on a hit or a get");

  // Every item in the request register yields one result on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_valid |=> done)
    else $error("result strobe missing");

endmodule

`default_nettype wire

// ===== dv/lru_key_value_cache_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the LRU key-value cache.
// Items go in on the start/busy handshake and every item gives exactly one
// result, marked by done. A behavioural copy of the cache runs alongside the
// block. For each item that the block takes, it works out the result and
// queues it. The result checker then compares every done cycle, field by
// field, with the oldest queued result.
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int SLOTS = 16;
  localparam int RANDOM_ITEMS = 400;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  req_t             request = '0;
  logic             done;
  rsp_t             result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  lru_key_value_cache #(
    .ENTRIES(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the cache. Ages count up from zero for the most recent
  // entry, so the live entries always hold the ages 0 .. fill-1, each once.
  logic signed [31:0] shadow_key [SLOTS];
  logic signed [31:0] shadow_value [SLOTS];
  bit                 shadow_live [SLOTS];
  int unsigned        shadow_age [SLOTS];
  int unsigned        shadow_fill;
  logic [CAP_W-1:0]   shadow_cap;

  // Results still to come from the block, oldest first.
  rsp_t pending_results[$];
  rsp_t oldest_result;

  // Keys that the traffic mostly draws from, so that gets and puts hit.
  logic signed [31:0] key_pool[$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned hits_predicted = 0;
  int unsigned evictions_predicted = 0;
  int unsigned cap_writes = 0;

  function automatic void shadow_reset();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_key[i] = '0;
      shadow_value[i] = '0;
      shadow_live[i] = 1'b0;
      shadow_age[i] = 0;
    end
    shadow_fill = 0;
    shadow_cap = CAP_RESET;
  endfunction

  // A capacity of zero behaves as one, and anything above the slot count
  // behaves as a full store, although the register keeps the bits written.
  function automatic int unsigned shadow_limit();
    if (shadow_cap < 1) return 1;
    if (shadow_cap > SLOTS) return SLOTS;
    return shadow_cap;
  endfunction

  // Makes one slot the most recent. Every other live slot younger than the
  // bound grows one step older.
  function automatic void shadow_touch(int slot, int unsigned bound);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_live[i] && i != slot && shadow_age[i] < bound) shadow_age[i]++;
    end
    shadow_age[slot] = 0;
  endfunction

  // Applies one item to the shadow cache and returns the result it causes.
  function automatic rsp_t cache_predict(req_t item);
    rsp_t        r;
    int          hit;
    int          slot;
    int unsigned oldest;
    r = '0;
    hit = -1;
    slot = -1;
    oldest = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && shadow_live[i] && shadow_key[i] == item.key) hit = i;
    end
    if (hit >= 0) begin
      r.found = 1'b1;
      if (item.kind == KIND_GET) r.read_value = shadow_value[hit];
      else shadow_value[hit] = item.value;
      shadow_touch(hit, shadow_age[hit]);
    end else if (item.kind == KIND_GET) begin
      r.read_value = MISS_VALUE;
    end else begin
      // A full store gives up its oldest entry to make room.
      if (shadow_fill >= shadow_limit()) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_live[i] && (slot < 0 || shadow_age[i] > oldest)) begin
            slot = i;
            oldest = shadow_age[i];
          end
        end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = shadow_key[slot];
          shadow_live[slot] = 1'b0;
          shadow_fill--;
        end
      end
      // Otherwise the new pair goes into the lowest free slot.
      if (slot < 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !shadow_live[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        shadow_key[slot] = item.key;
        shadow_value[slot] = item.value;
        shadow_touch(slot, 32'hFFFF_FFFF);
        shadow_live[slot] = 1'b1;
        shadow_fill++;
      end
    end
    return r;
  endfunction

  // Fills the key pool with the four extreme keys and then distinct random
  // keys, a few more than the store can hold, so that evictions keep coming.
  function automatic void build_key_pool(int unsigned pool_size);
    logic signed [31:0] k;
    bit                 seen;
    key_pool.delete();
    key_pool.push_back(32'sh8000_0000);
    key_pool.push_back(32'sh7FFF_FFFF);
    key_pool.push_back(32'sh0000_0000);
    key_pool.push_back(-32'sd1);
    while (key_pool.size() < pool_size) begin
      k = $urandom;
      seen = 1'b0;
      foreach (key_pool[i]) if (key_pool[i] == k) seen = 1'b1;
      if (!seen) key_pool.push_back(k);
    end
  endfunction

  // Mostly pool keys, with a share of fully random keys, and fully random values,
  // so that every bit of every field is exercised.
  function automatic req_t random_item();
    req_t item;
    item.kind = ($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET;
    if ($urandom_range(0, 99) < 80) item.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else item.key = $urandom;
    item.value = $urandom;
    return item;
  endfunction

  // Presents one item and holds it until the block takes it. start is left
  // high, so a following item goes out on the very next cycle.
  task automatic send_item(input req_t item, output rsp_t predicted);
    start <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = cache_predict(item);
    pending_results.push_back(predicted);
    items_sent++;
    if (predicted.found) hits_predicted++;
    if (predicted.evicted) evictions_predicted++;
  endtask

  task automatic idle_for(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending and waits for every outstanding result. Every item has a
  // result, so once the queue is empty the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Capacity writes are made only with the block idle. The shadow copy takes
  // the new value only while the store is empty, as the block does.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (shadow_fill == 0) shadow_cap = cap;
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  task automatic send_op(input logic kind, input logic signed [31:0] key,
                         input logic signed [31:0] value);
    req_t item;
    rsp_t predicted;
    item.kind = kind;
    item.key = key;
    item.value = value;
    send_item(item, predicted);
  endtask

  task automatic send_op_random();
    rsp_t predicted;
    send_item(random_item(), predicted);
  endtask

  // While the store is still empty, capacity writes take effect, including
  // zero and values beyond the slot count. Gets in between must all miss.
  // The last write picks the capacity for the rest of the run, since the
  // store never empties again without a reset.
  task automatic test_empty_store();
    logic [CAP_W-1:0] caps [7];
    caps = '{5'd0, 5'd1, 5'd2, 5'd4, 5'd7, 5'd16, 5'd31};
    write_capacity(5'd31);
    send_op(KIND_GET, 32'sh8000_0000, 32'sh7FFF_FFFF);
    write_capacity(5'd0);
    send_op(KIND_GET, 32'sh7FFF_FFFF, 32'sh8000_0000);
    write_capacity(5'd17);
    send_op(KIND_GET, 32'sh0000_0000, -32'sd1);
    write_capacity(caps[$urandom_range(0, 6)]);
    build_key_pool(shadow_limit() + 4);
  endtask

  // Each operation with the extreme keys and values: put misses, get hits,
  // a put that overwrites where the capacity holds both keys, and a get that misses.
  task automatic test_basic_ops();
    send_op(KIND_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_op(KIND_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_op(KIND_GET, 32'sh8000_0000, 32'sh0000_0000);
    send_op(KIND_GET, 32'sh7FFF_FFFF, -32'sd1);
    send_op(KIND_PUT, 32'sh8000_0000, 32'sh0000_0000);
    send_op(KIND_GET, -32'sd1, 32'sh1234_5678);
  endtask

  // Puts fresh keys back to back until the store is full and one entry is
  // thrown out, then asks for that entry, which must now miss.
  task automatic test_fill_and_evict();
    req_t        item;
    rsp_t        predicted;
    int unsigned idx;
    logic signed [31:0] victim;
    idx = 2;
    predicted = '0;
    while (!predicted.evicted && idx < key_pool.size()) begin
      item.kind = KIND_PUT;
      item.key = key_pool[idx];
      item.value = $urandom;
      send_item(item, predicted);
      idx++;
    end
    victim = predicted.evicted_key;
    send_op(KIND_GET, victim, 32'sh0000_0000);
    drain();
  endtask

  // With the store holding entries, capacity writes must be ignored. Traffic
  // after each write shows whether the eviction point moved.
  task automatic test_capacity_locked();
    logic [CAP_W-1:0] caps [3];
    caps = '{5'd1, 5'd31, 5'd0};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      repeat (20) send_op_random();
    end
  endtask

  // Bursts of random length with random gaps, about a quarter of them run
  // straight into the next burst. Half way through the sender stops and waits
  // for every outstanding result before carrying on.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_op_random();
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain();
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
    end
  endtask

  // Result checker. The block cannot be held off, so every cycle with done
  // high is a result, to be matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: found %0d read_value %0d evicted %0d key %0d",
               result.found, result.read_value, result.evicted, result.evicted_key);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        if (result.found !== oldest_result.found) begin
          $error("found: expected %0d, actual %0d", oldest_result.found, result.found);
          errors++;
        end
        if (result.read_value !== oldest_result.read_value) begin
          $error("read_value: expected %0d, actual %0d",
                 oldest_result.read_value, result.read_value);
          errors++;
        end
        if (result.evicted !== oldest_result.evicted) begin
          $error("evicted: expected %0d, actual %0d", oldest_result.evicted, result.evicted);
          errors++;
        end
        if (result.evicted_key !== oldest_result.evicted_key) begin
          $error("evicted_key: expected %0d, actual %0d",
                 oldest_result.evicted_key, result.evicted_key);
          errors++;
        end
      end
    end
  end

  initial begin
    shadow_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_basic_ops();
    test_fill_and_evict();
    test_capacity_locked();
    test_random_traffic();
    drain();
    // A few quiet cycles catch any stray result after the last one.
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors += pending_results.size();
    end
    $display("Run covered %0d items and %0d results, with %0d hits and %0d evictions,",
             items_sent, results_checked, hits_predicted, evictions_predicted);
    $display("after %0d capacity writes; working capacity %0d, %0d errors.",
             cap_writes, shadow_limit(), errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
